>>> rtl/u2u_pkg.sv
package u2u_pkg;

    // Lead byte classes, taken from bit7, bit5 and bit4
    typedef enum logic [1:0] {
        LEAD_ASCII = 2'd0,
        LEAD_TWO   = 2'd1,
        LEAD_THREE = 2'd2,
        LEAD_FOUR  = 2'd3
    } t_lead;

    // One classified request on its way from front to back
    typedef struct packed {
        t_lead      lead;
        logic [7:0] data;
        logic       last;
    } t_op;

    localparam logic [15:0] STAND_IN  = 16'h0058;
    localparam logic [7:0]  MASK_TWO  = 8'h1f;
    localparam logic [7:0]  MASK_THR  = 8'h0f;
    localparam logic [7:0]  MASK_CONT = 8'h3f;

    localparam logic [1:0]  PEND_TWO  = 2'd1;
    localparam logic [1:0]  PEND_THR  = 2'd2;
    localparam logic [1:0]  PEND_SKIP = 2'd3;

    // Queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

endpackage

>>> rtl/u2u_front.sv
module u2u_front
    import u2u_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output t_op        o_op
);

    logic  r_valid;
    logic  n_valid;
    t_op   r_op;
    t_lead w_lead;

    // Class of the byte if it turns out to be a lead byte
    always_comb begin
        unique case ({i_byte[7], i_byte[5], i_byte[4]}) inside
            3'b0??:  w_lead = LEAD_ASCII;
            3'b10?:  w_lead = LEAD_TWO;
            3'b110:  w_lead = LEAD_THREE;
            default: w_lead = LEAD_FOUR;
        endcase
    end

    // Single holding stage; takes a new request whenever the slot drains
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op.lead <= w_lead;
            r_op.data <= i_byte;
            r_op.last <= i_last;
        end
    end

endmodule

>>> rtl/u2u_queue.sv
module u2u_queue
    import u2u_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_op  i_op,
    output logic o_valid,
    input  logic i_ready,
    output t_op  o_op
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] ptr);
        f_next = (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

>>> rtl/u2u_back.sv
module u2u_back
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_op         i_op,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_substituted
);

    logic [1:0]  r_pending;
    logic        r_skipping;
    logic [15:0] r_acc;
    logic        r_out_valid;
    logic [15:0] r_code;
    logic        r_sub;

    logic [1:0]  n_pending;
    logic        n_skipping;
    logic [15:0] n_acc;
    logic        w_emit;
    logic [15:0] w_code;
    logic        w_sub;
    logic        w_pop;

    // Output register frees up when empty or being taken
    assign o_ready       = !r_out_valid || i_ready;
    assign w_pop         = i_valid && o_ready;
    assign o_valid       = r_out_valid;
    assign o_code_unit   = r_code;
    assign o_substituted = r_sub;

    // Sequence tracking and accumulation
    always_comb begin
        n_pending  = r_pending;
        n_skipping = r_skipping;
        n_acc      = r_acc;
        w_emit     = 1'b0;
        w_code     = 16'({8'h00, i_op.data});
        w_sub      = 1'b0;
        if (r_pending == 2'd0) begin
            unique case (i_op.lead)
                LEAD_ASCII: begin
                    w_emit = 1'b1;
                end
                LEAD_TWO: begin
                    n_acc      = {8'h00, i_op.data & MASK_TWO};
                    n_pending  = PEND_TWO;
                    n_skipping = 1'b0;
                end
                LEAD_THREE: begin
                    n_acc      = {8'h00, i_op.data & MASK_THR};
                    n_pending  = PEND_THR;
                    n_skipping = 1'b0;
                end
                default: begin
                    w_emit     = 1'b1;
                    w_code     = STAND_IN;
                    w_sub      = 1'b1;
                    n_pending  = PEND_SKIP;
                    n_skipping = 1'b1;
                end
            endcase
        end else begin
            n_pending = r_pending - 1'b1;
            if (r_skipping) begin
                if (n_pending == 2'd0) begin
                    n_skipping = 1'b0;
                end
            end else begin
                n_acc = {r_acc[9:0], 6'b0} + {8'h00, i_op.data & MASK_CONT};
                if (n_pending == 2'd0) begin
                    w_emit = 1'b1;
                    w_code = n_acc;
                end
            end
        end
        // End of string drops any unfinished sequence
        if (i_op.last) begin
            n_pending  = 2'd0;
            n_skipping = 1'b0;
            n_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_skipping  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_pending  <= n_pending;
                r_skipping <= n_skipping;
                r_acc      <= n_acc;
            end
            if (o_ready) begin
                r_out_valid <= w_pop && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_code <= w_code;
            r_sub  <= w_sub;
        end
    end

endmodule

>>> rtl/utf8_to_ucs2_decoder.sv
// Channel   Valid          Ready          Payload
// input     i_in_valid     o_in_ready     i_in_byte, i_last_byte
// output    o_out_valid    i_out_ready    o_code_unit, o_substituted
//
// One byte a cycle sustained while the output does not stall; the last byte of
// a result passes the front register and the queue before the back register.
// The path runs through the front holding register, a 2-entry queue and the
// back output register. Reset clears all valid flags and the decode state.
// A stall on the output fills the queue, then the front stage, before
// o_in_ready drops; while a result waits in the back output register the
// back stage takes no byte, even one that gives no result.
module utf8_to_ucs2_decoder
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic        o_substituted
);

    logic w_f_valid;
    logic w_f_ready;
    t_op  w_f_op;
    logic w_q_valid;
    logic w_q_ready;
    t_op  w_q_op;

    u2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_in_byte),
        .i_last  (i_last_byte),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_op    (w_f_op)
    );

    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_op    (w_f_op),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_op    (w_q_op)
    );

    u2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_ready       (w_q_ready),
        .i_op          (w_q_op),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_code_unit   (o_code_unit),
        .o_substituted (o_substituted)
    );

endmodule

>>> verif/utf8_to_ucs2_decoder_tb.sv
// One expected code unit
typedef struct {
    logic [15:0] unit;
    logic        subst;
} due_unit_t;

// Tracks the decode state of the byte stream and checks the code units
class code_unit_checker;
    logic [1:0]  pend_cnt;
    logic        drop_mode;
    logic [15:0] partial;
    due_unit_t   due_units[$];
    int          errors;

    function new();
        pend_cnt  = '0;
        drop_mode = 1'b0;
        partial   = '0;
        errors    = 0;
    endfunction

    // Note one accepted request and queue the code unit it yields, if any
    function void note_byte(logic [7:0] b, logic last);
        due_unit_t      u;
        u2u_pkg::t_lead lead;
        if (pend_cnt == 2'd0) begin
            if (!b[7])
                lead = u2u_pkg::LEAD_ASCII;
            else if (!b[5])
                lead = u2u_pkg::LEAD_TWO;
            else if (!b[4])
                lead = u2u_pkg::LEAD_THREE;
            else
                lead = u2u_pkg::LEAD_FOUR;
            case (lead)
                u2u_pkg::LEAD_ASCII: begin
                    u.unit  = {8'h00, b};
                    u.subst = 1'b0;
                    due_units.insert(due_units.size(), u);
                end
                u2u_pkg::LEAD_TWO: begin
                    partial   = {8'h00, b & u2u_pkg::MASK_TWO};
                    pend_cnt  = u2u_pkg::PEND_TWO;
                    drop_mode = 1'b0;
                end
                u2u_pkg::LEAD_THREE: begin
                    partial   = {8'h00, b & u2u_pkg::MASK_THR};
                    pend_cnt  = u2u_pkg::PEND_THR;
                    drop_mode = 1'b0;
                end
                default: begin
                    // beyond the BMP: stand-in now, drop three bytes
                    u.unit    = u2u_pkg::STAND_IN;
                    u.subst   = 1'b1;
                    due_units.insert(due_units.size(), u);
                    pend_cnt  = u2u_pkg::PEND_SKIP;
                    drop_mode = 1'b1;
                end
            endcase
        end else begin
            pend_cnt = pend_cnt - 2'd1;
            if (drop_mode) begin
                if (pend_cnt == 2'd0)
                    drop_mode = 1'b0;
            end else begin
                partial = {partial[9:0], 6'b0} + {8'h00, b & u2u_pkg::MASK_CONT};
                if (pend_cnt == 2'd0) begin
                    u.unit  = partial;
                    u.subst = 1'b0;
                    due_units.insert(due_units.size(), u);
                end
            end
        end
        // end of string drops any partial sequence
        if (last) begin
            pend_cnt  = '0;
            drop_mode = 1'b0;
            partial   = '0;
        end
    endfunction

    // Compare one accepted result with the oldest expected unit
    function void check_unit(logic [15:0] code, logic subst);
        due_unit_t u;
        if (due_units.size() == 0) begin
            $error("unexpected result: code_unit=%h substituted=%b", code, subst);
            errors++;
            return;
        end
        u = due_units.pop_front();
        if (code !== u.unit) begin
            $error("code_unit mismatch: expected %h, actual %h", u.unit, code);
            errors++;
        end
        if (subst !== u.subst) begin
            $error("substituted mismatch: expected %b, actual %b", u.subst, subst);
            errors++;
        end
    endfunction
endclass

module utf8_to_ucs2_decoder_tb;
    import u2u_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_substituted;

    code_unit_checker sb;

    int send_idle_pct;
    int stall_pct;
    int byte_count;
    int hold_req_cnt;
    int hold_ack_cnt = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    utf8_to_ucs2_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_unit   (o_code_unit),
        .o_substituted (o_substituted)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Offer one request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_byte   <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_byte(b, last);
        byte_count++;
    endtask

    // Continuation byte, mostly well formed
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(99) < 85)
            return {2'b10, 6'($urandom_range(63))};
        return 8'($urandom_range(255));
    endfunction

    // End-of-string flag now and then, on any byte
    function automatic logic rand_last();
        return ($urandom_range(29) == 0);
    endfunction

    // One random character: mostly whole sequences, some noise
    task automatic send_random_char();
        int          pick;
        logic [7:0]  lead;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_byte(8'($urandom_range(127)), rand_last());
        end else if (pick < 50) begin
            lead = {3'b110, 5'($urandom_range(31))};
            if ($urandom_range(9) == 0)
                lead[6] = 1'b0;
            send_byte(lead, rand_last());
            send_byte(cont_byte(), rand_last());
        end else if (pick < 75) begin
            lead = {4'b1110, 4'($urandom_range(15))};
            if ($urandom_range(9) == 0)
                lead[6] = 1'b0;
            send_byte(lead, rand_last());
            send_byte(cont_byte(), rand_last());
            send_byte(cont_byte(), rand_last());
        end else if (pick < 85) begin
            lead = {4'b1111, 4'($urandom_range(15))};
            if ($urandom_range(9) == 0)
                lead[6] = 1'b0;
            send_byte(lead, rand_last());
            repeat (3)
                send_byte(8'($urandom_range(255)), rand_last());
        end else begin
            send_byte(8'($urandom_range(255)), rand_last());
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = byte_count + count;
        while (byte_count < target)
            send_random_char();
    endtask

    // Result side: random stalls plus the long hold-off on request
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_unit(o_code_unit, o_substituted);
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("utf8_to_ucs2_decoder test failed");
            $finish;
        end
    end

    initial begin
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        byte_count    = 0;
        hold_req_cnt  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        i_last_byte   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        // two-byte extremes
        send_byte(8'hc2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hdf, 1'b0);
        send_byte(8'hbf, 1'b0);
        // three-byte extremes
        send_byte(8'he0, 1'b0);
        send_byte(8'ha0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        // bare 10xxxxxx leads, with malformed continuations
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hc0, 1'b0);
        // four-byte lead: stand-in, three bytes dropped
        send_byte(8'hf0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // truncated three-byte tail at end of string
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        // end flag on plain, two-byte and four-byte leads
        send_byte(8'h41, 1'b1);
        send_byte(8'hc3, 1'b1);
        send_byte(8'hff, 1'b1);

        // Long hold-off on results while requests keep coming
        hold_req_cnt++;
        repeat (60)
            send_byte(8'($urandom_range(127)), 1'b0);
        run_random(240);

        send_idle_pct = 83;
        stall_pct     = 0;
        run_random(300);

        send_idle_pct = 0;
        stall_pct     = 83;
        run_random(300);

        send_idle_pct = 33;
        stall_pct     = 33;
        run_random(300);

        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(200);

        i_in_valid <= 1'b0;
        while (sb.due_units.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.due_units.size() == 0)
            $display("utf8_to_ucs2_decoder test passed");
        else
            $display("utf8_to_ucs2_decoder test failed");
        $finish;
    end

endmodule
